// ----- rtl/length_prefixed_record_framer_assert.svh -----
// Assertion macros for the record framer.
// Used by the top level; needs no package.
`ifndef LENGTH_PREFIXED_RECORD_FRAMER_ASSERT_SVH
`define LENGTH_PREFIXED_RECORD_FRAMER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LPRF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LPRF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/lprf_pkg.sv -----
// Shared types and codes for the length-prefixed record framer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package lprf_pkg;

    localparam int unsigned CMD_W     = 3;
    localparam int unsigned PLEN_W    = 16;
    localparam int unsigned CLEN_W    = 64;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned BURST_MAX = 9;
    localparam int unsigned CNT_W     = 4;
    localparam int unsigned BURST_W   = BURST_MAX * BYTE_W;

    // Commands carried by an input item.
    localparam logic [CMD_W-1:0] CMD_START   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PATH    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CONTENT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_END     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_STOP    = 3'd4;

    // Framer stages.
    localparam logic [1:0] STAGE_START   = 2'd0;
    localparam logic [1:0] STAGE_PATH    = 2'd1;
    localparam logic [1:0] STAGE_CONTENT = 2'd2;

    // Error codes.
    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_STAGE = 2'd1;
    localparam logic [1:0] ERR_DONE  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [PLEN_W-1:0] path_length;
        logic              is_directory;
        logic [CLEN_W-1:0] content_length;
        logic [BYTE_W-1:0] data_byte;
    } t_item;

    // All results caused by one item: bytes in emit order from bit 0 up.
    typedef struct packed {
        logic [BURST_W-1:0] bytes;
        logic [CNT_W-1:0]   count;
        logic               has_byte;
        logic               done_res;
        logic               stopped;
        logic               inside_file;
        logic [1:0]         error_code;
    } t_burst;

endpackage
`default_nettype wire

// ----- rtl/lprf_core.sv -----
// Record state machine of the framer: turns one item into a burst of results.
// Depends on lprf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lprf_core (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_wr_en,
    input  wire logic [lprf_pkg::CLEN_W-1:0] i_cfg_wr_data,
    input  wire logic                       i_step,
    input  wire lprf_pkg::t_item            i_item,
    output lprf_pkg::t_burst                o_burst
);
    import lprf_pkg::*;

    logic [CLEN_W-1:0] r_dir_marker;
    logic [1:0]        r_stage,        n_stage;
    logic [PLEN_W-1:0] r_path_rem,     n_path_rem;
    logic              r_rec_dir,      n_rec_dir;
    logic [CLEN_W-1:0] r_len_field,    n_len_field;
    logic [CLEN_W-1:0] r_content_rem,  n_content_rem;
    logic              r_done,         n_done;
    logic              r_stop_pending, n_stop_pending;
    logic              r_stop_reached, n_stop_reached;

    logic [PLEN_W-1:0] path_dec;
    logic [CLEN_W-1:0] content_dec;
    logic [BURST_W-1:0] bytes;
    logic [CNT_W-1:0]   count;
    logic [1:0]         err;

    assign path_dec    = r_path_rem - PLEN_W'(1);
    assign content_dec = r_content_rem - CLEN_W'(1);

    always_comb begin
        n_stage        = r_stage;
        n_path_rem     = r_path_rem;
        n_rec_dir      = r_rec_dir;
        n_len_field    = r_len_field;
        n_content_rem  = r_content_rem;
        n_done         = r_done;
        n_stop_pending = r_stop_pending;
        n_stop_reached = r_stop_reached;
        bytes          = '0;
        count          = '0;
        err            = ERR_OK;

        if (r_done) begin
            err = ERR_DONE;
        end else if (i_item.command == CMD_START && r_stage == STAGE_START) begin
            bytes[2*BYTE_W-1:0] = i_item.path_length;
            count = CNT_W'(2);
            if (i_item.path_length == '0) begin
                n_done = 1'b1;
            end else begin
                n_rec_dir     = i_item.is_directory;
                n_len_field   = i_item.is_directory ? r_dir_marker : i_item.content_length;
                n_content_rem = i_item.is_directory ? '0 : i_item.content_length;
                n_path_rem    = i_item.path_length;
                n_stage       = STAGE_PATH;
            end
        end else if (i_item.command == CMD_PATH && r_stage == STAGE_PATH) begin
            bytes[BYTE_W-1:0] = i_item.data_byte;
            count      = CNT_W'(1);
            n_path_rem = path_dec;
            if (path_dec == '0) begin
                // Last path byte: the 8-byte length field follows in the same burst.
                bytes[BURST_W-1:BYTE_W] = r_len_field;
                count   = CNT_W'(BURST_MAX);
                n_stage = STAGE_START;
                if (!r_rec_dir && r_content_rem != '0) begin
                    n_stage = STAGE_CONTENT;
                end else if (!r_rec_dir && r_stop_pending) begin
                    n_stop_reached = 1'b1;
                    n_done         = 1'b1;
                end
            end
        end else if (i_item.command == CMD_CONTENT && r_stage == STAGE_CONTENT) begin
            bytes[BYTE_W-1:0] = i_item.data_byte;
            count         = CNT_W'(1);
            n_content_rem = content_dec;
            if (content_dec == '0) begin
                n_stage = STAGE_START;
                if (!r_rec_dir && r_stop_pending) begin
                    n_stop_reached = 1'b1;
                    n_done         = 1'b1;
                end
            end
        end else if (i_item.command == CMD_END && r_stage == STAGE_START) begin
            count  = CNT_W'(2);
            n_done = 1'b1;
        end else if (i_item.command == CMD_STOP) begin
            n_stop_pending = 1'b1;
        end else begin
            err = ERR_STAGE;
        end
    end

    always_comb begin
        o_burst.bytes       = bytes;
        o_burst.has_byte    = (count != '0);
        o_burst.count       = (count == '0) ? CNT_W'(1) : count;
        o_burst.done_res    = n_done;
        o_burst.stopped     = n_stop_reached;
        o_burst.inside_file = (n_stage == STAGE_CONTENT) && !n_done;
        o_burst.error_code  = err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir_marker   <= '1;
            r_stage        <= STAGE_START;
            r_path_rem     <= '0;
            r_rec_dir      <= 1'b0;
            r_len_field    <= '0;
            r_content_rem  <= '0;
            r_done         <= 1'b0;
            r_stop_pending <= 1'b0;
            r_stop_reached <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_dir_marker <= i_cfg_wr_data;
            end
            if (i_step) begin
                r_stage        <= n_stage;
                r_path_rem     <= n_path_rem;
                r_rec_dir      <= n_rec_dir;
                r_len_field    <= n_len_field;
                r_content_rem  <= n_content_rem;
                r_done         <= n_done;
                r_stop_pending <= n_stop_pending;
                r_stop_reached <= n_stop_reached;
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/lprf_emit.sv -----
// Framer result register: holds one burst, shifts out a byte per cycle when ready.
// Depends on lprf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lprf_emit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_load,
    input  wire lprf_pkg::t_burst           i_burst,
    output logic                            o_free,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [lprf_pkg::BYTE_W-1:0]     o_byte,
    output logic                            o_has_byte,
    output logic                            o_last,
    output logic                            o_done_res,
    output logic                            o_stopped,
    output logic                            o_inside_file,
    output logic [1:0]                      o_error_code
);
    import lprf_pkg::*;

    logic               r_vld;
    logic [BURST_W-1:0] r_bytes;
    logic [CNT_W-1:0]   r_left;
    logic               r_has_byte, r_done_res, r_stopped, r_inside, r_last_q;
    logic [1:0]         r_err;
    logic               take;

    assign take    = r_vld && i_ready;
    assign r_last_q = (r_left == CNT_W'(1));
    assign o_free  = !r_vld || (take && r_last_q);

    assign o_valid       = r_vld;
    assign o_byte        = r_bytes[BYTE_W-1:0];
    assign o_has_byte    = r_has_byte;
    assign o_last        = r_last_q;
    assign o_done_res    = r_done_res;
    assign o_stopped     = r_stopped;
    assign o_inside_file = r_inside;
    assign o_error_code  = r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_left <= '0;
        end else if (i_load) begin
            r_vld  <= 1'b1;
            r_left <= i_burst.count;
        end else if (take) begin
            r_vld  <= !r_last_q;
            r_left <= r_left - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes    <= i_burst.bytes;
            r_has_byte <= i_burst.has_byte;
            r_done_res <= i_burst.done_res;
            r_stopped  <= i_burst.stopped;
            r_inside   <= i_burst.inside_file;
            r_err      <= i_burst.error_code;
        end else if (take) begin
            r_bytes <= {{BYTE_W{1'b0}}, r_bytes[BURST_W-1:BYTE_W]};
        end
    end

endmodule
`default_nettype wire

// ----- rtl/length_prefixed_record_framer.sv -----
// Top level of the length-prefixed record framer: input register, record core, result emitter.
// Depends on lprf_pkg, lprf_core, lprf_emit and length_prefixed_record_framer_assert.svh.
//
// Usage: record items enter on the s_axis group. The command travels in s_axis_tuser;
// s_axis_tdata carries path_length, is_directory, content_length and data_byte. Each
// item yields one to nine results on the m_axis group, one result per handshake: a
// start item gives the two path-length bytes, a path byte gives itself, and the final
// path byte also gives the eight length-field bytes. Stop requests, errors and items
// after the end of the stream give a single status result with tuser (has_byte) low.
// m_axis_tlast marks the final result of each item.
// An accepted item waits in the input register until the result register is free; its
// first result is valid once loaded. Throughput is one item per cycle while each item
// gives one result and the receiver is ready; an item with several results holds the
// emitter until all are taken, which sets the rate during header bursts. The input
// register lets one further item be accepted while results wait on a stalled receiver;
// tready then drops until the emitter drains. The directory marker is written through
// i_cfg_wr_en / i_cfg_wr_data; the user must do so only while idle, the block does not check.
// Reset is synchronous: it clears both pipeline registers and the record state, and
// sets the directory marker to all ones.
`timescale 1ns / 1ps
`default_nettype none
`include "length_prefixed_record_framer_assert.svh"
module length_prefixed_record_framer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [63:0] i_cfg_wr_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // Fields from bit 0: path_length[15:0], is_directory[16], content_length[80:17],
    // data_byte[88:81], zero fill [95:89].
    input  wire logic [95:0] s_axis_tdata,
    // Fields from bit 0: command[2:0].
    input  wire logic [2:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // Fields from bit 0: out_byte[7:0], done_res[8], stopped[9], inside_file[10],
    // error_code[12:11], zero fill [15:13].
    output logic [15:0]      m_axis_tdata,
    // Fields from bit 0: has_byte[0].
    output logic             m_axis_tuser,
    output logic             m_axis_tlast
);
    import lprf_pkg::*;

    // Input register: holds one item until the emitter can take its burst.
    logic   r_in_vld;
    t_item  r_in;
    logic   load;
    logic   emit_free;
    t_burst burst;

    logic [BYTE_W-1:0] out_byte;
    logic              done_res, stopped, inside_file;
    logic [1:0]        error_code;

    assign load          = r_in_vld && emit_free;
    assign s_axis_tready = !r_in_vld || load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_vld <= 1'b1;
        end else if (load) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.command        <= s_axis_tuser;
            r_in.path_length    <= s_axis_tdata[15:0];
            r_in.is_directory   <= s_axis_tdata[16];
            r_in.content_length <= s_axis_tdata[80:17];
            r_in.data_byte      <= s_axis_tdata[88:81];
        end
    end

    // The record state advances exactly when the item's burst enters the emitter.
    lprf_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_step        (load),
        .i_item        (r_in),
        .o_burst       (burst)
    );

    lprf_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (load),
        .i_burst       (burst),
        .o_free        (emit_free),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_byte        (out_byte),
        .o_has_byte    (m_axis_tuser),
        .o_last        (m_axis_tlast),
        .o_done_res    (done_res),
        .o_stopped     (stopped),
        .o_inside_file (inside_file),
        .o_error_code  (error_code)
    );

    assign m_axis_tdata = {3'b000, error_code, inside_file, stopped, done_res, out_byte};

    // A status result stands alone, so it must close its item.
    `LPRF_ASSERT_NOW(a_status_is_last, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tlast, "status result without tlast")
    // An error never comes with a stream byte.
    `LPRF_ASSERT_NOW(a_error_no_byte, i_clk, i_rst_n, m_axis_tvalid && (error_code != ERR_OK), !m_axis_tuser, "error result carries a byte")
    // A buffered item that could not be loaded stays buffered.
    `LPRF_ASSERT_NEXT(a_in_held, i_clk, i_rst_n, r_in_vld && !load, r_in_vld, "buffered item lost")

endmodule
`default_nettype wire
